>>> design/view_frustum_cull_top_defines.svh
// Assertion macros for the view frustum cull block.
`ifndef VIEW_FRUSTUM_CULL_TOP_DEFINES_SVH
`define VIEW_FRUSTUM_CULL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define VFC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define VFC_ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define VFC_ASSERT(label, clk, rst_n, prop)
`define VFC_ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> design/vfc_pkg.sv
// Shared types and constants for the view frustum cull block.
package vfc_pkg;
	localparam int NumPlanes = 6;
	localparam int NumCorners = 8;
	localparam int CoordW = 24;
	localparam int CoefW = 36;
	// Product of a 36-bit coefficient and a 24-bit coordinate term, plus headroom.
	localparam int ProdW = 62;
	localparam int SumW = 64;

	localparam logic CmdPoint = 1'b0;
	localparam logic CmdBox = 1'b1;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [CoefW-1:0] coef_t;

	typedef struct packed {
		logic cmd;
		coord_t x_min;
		coord_t y_min;
		coord_t z_min;
		coord_t x_max;
		coord_t y_max;
		coord_t z_max;
	} item_t;
endpackage

>>> design/vfc_planes.sv
// Configuration registers, matrix product and plane coefficient extraction.
module vfc_planes (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [5:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output vfc_pkg::coef_t coef [vfc_pkg::NumPlanes][4],
	output logic coef_busy
);
	logic [63:0] regs_q [8];
	logic signed [33:0] m_q [4][4];
	logic signed [34:0] pl [vfc_pkg::NumPlanes][4];
	logic cfg_wr;
	// Marks the cycles in which the product and the planes still lag the registers.
	logic [1:0] stale_q;

	assign cfg_wr = psel && penable && pwrite && paddr[2:0] == 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) begin
				regs_q[r] <= 64'd256 << (16 * r);
				regs_q[r+4] <= 64'd256 << (16 * r);
			end
		end else if (cfg_wr) begin
			regs_q[paddr[5:3]] <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q <= 2'b11;
		end else begin
			stale_q <= {stale_q[0], cfg_wr};
		end
	end

	assign coef_busy = |stale_q;

	assign prdata = regs_q[paddr[5:3]];

	// Matrix product, registered; config is to be kept static while items run, which the block does not enforce.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				logic signed [33:0] s;
				s = '0;
				for (int k = 0; k < 4; k++) begin
					s = s + 34'(signed'(regs_q[i][16*k +: 16]) *
						signed'(regs_q[4+k][16*j +: 16]));
				end
				m_q[i][j] <= s;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pl[0][i] = 35'(m_q[i][3]) + 35'(m_q[i][0]);
			pl[1][i] = 35'(m_q[i][3]) - 35'(m_q[i][0]);
			pl[2][i] = 35'(m_q[i][3]) + 35'(m_q[i][1]);
			pl[3][i] = 35'(m_q[i][3]) - 35'(m_q[i][1]);
			pl[4][i] = 35'(m_q[i][2]);
			pl[5][i] = 35'(m_q[i][3]) - 35'(m_q[i][2]);
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < vfc_pkg::NumPlanes; p++) begin
			for (int i = 0; i < 4; i++) begin
				coef[p][i] <= vfc_pkg::CoefW'(pl[p][i]);
			end
		end
	end
endmodule

>>> design/vfc_front.sv
// Front end: accepts items and queues them in a short FIFO.
module vfc_front #(
	parameter int Depth = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  vfc_pkg::item_t in_item,
	output logic q_valid,
	input  logic q_ready,
	output vfc_pkg::item_t q_item
);
	localparam int AW = $clog2(Depth);
	vfc_pkg::item_t mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != (AW+1)'(Depth));
	assign q_valid = (cnt_q != '0);
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

>>> design/vfc_back.sv
// Back end: three-stage plane test pipeline with output register.
module vfc_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  vfc_pkg::item_t q_item,
	input  vfc_pkg::coef_t coef [vfc_pkg::NumPlanes][4],
	input  logic coef_busy,
	output logic out_valid,
	input  logic out_ready,
	output logic inside_res
);
	localparam int PW = vfc_pkg::ProdW;
	localparam int SW = vfc_pkg::SumW;
	logic v_s1, v_s2, v_s3;
	logic cmd_s1, cmd_s2;
	logic adv;
	// Per plane, per axis, products with min and max coordinate.
	logic signed [PW-1:0] plo_s1 [vfc_pkg::NumPlanes][3];
	logic signed [PW-1:0] phi_s1 [vfc_pkg::NumPlanes][3];
	logic signed [PW-1:0] d_s1 [vfc_pkg::NumPlanes];
	logic [vfc_pkg::NumPlanes-1:0] cull_s2;
	logic res_s3;

	// The pipeline stalls as a whole only when the output holds an unread item.
	assign adv = !(v_s3 && !out_ready);
	// No item is taken while the plane coefficients are still being refreshed.
	assign q_ready = adv && !coef_busy;
	assign out_valid = v_s3;
	assign inside_res = res_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= q_item.cmd;
			for (int p = 0; p < vfc_pkg::NumPlanes; p++) begin
				plo_s1[p][0] <= PW'(coef[p][0] * q_item.x_min);
				plo_s1[p][1] <= PW'(coef[p][1] * q_item.y_min);
				plo_s1[p][2] <= PW'(coef[p][2] * q_item.z_min);
				phi_s1[p][0] <= PW'(coef[p][0] * q_item.x_max);
				phi_s1[p][1] <= PW'(coef[p][1] * q_item.y_max);
				phi_s1[p][2] <= PW'(coef[p][2] * q_item.z_max);
				d_s1[p] <= PW'(coef[p][3]) <<< 8;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2 <= cmd_s1;
			for (int p = 0; p < vfc_pkg::NumPlanes; p++) begin
				logic all_neg;
				logic signed [SW-1:0] v;
				all_neg = 1'b1;
				for (int k = 0; k < vfc_pkg::NumCorners; k++) begin
					v = SW'(k[0] ? phi_s1[p][0] : plo_s1[p][0])
						+ SW'(k[1] ? phi_s1[p][1] : plo_s1[p][1])
						+ SW'(k[2] ? phi_s1[p][2] : plo_s1[p][2])
						+ SW'(d_s1[p]);
					if (cmd_s1 == vfc_pkg::CmdPoint) begin
						if (k == 0) all_neg = v[SW-1];
					end else if (!v[SW-1]) begin
						all_neg = 1'b0;
					end
				end
				cull_s2[p] <= all_neg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s3 <= (cull_s2 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_valid && !coef_busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end
endmodule

>>> design/view_frustum_cull_top.sv
// Top level of the view frustum cull block.
// Usage: the view and projection matrices are written over the APB-style port
// (eight 64-bit registers at byte addresses 8*i) while the block is idle.
// Their product and the six plane equations are refreshed through the product
// and plane registers, and the back end takes no item from the queue until
// they are; the same holds after reset until they are first computed.
// Items enter on in valid/ready: command selects a point test (at the min
// coordinates) or a box test. Each item yields one result item, inside_res,
// on the out valid/ready channel, 1 when the item is not culled.
// An item enters a four-entry queue in the front end, so it may be accepted
// while results wait. The back end is a three-stage pipeline: multipliers,
// then the corner sums and sign tests, then the output register.
// Throughput is one item per cycle, set by the fully pipelined back end,
// while the receiver takes results and no coefficient refresh is pending.
// When the receiver stalls, the back pipeline holds and the queue fills;
// in_ready falls once the queue is full. Reset empties the queue and the
// pipeline and returns both matrices to identity.
`include "view_frustum_cull_top_defines.svh"
module view_frustum_cull_top #(
	parameter int QueueDepth = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [5:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic command,
	input  logic signed [23:0] x_min,
	input  logic signed [23:0] y_min,
	input  logic signed [23:0] z_min,
	input  logic signed [23:0] x_max,
	input  logic signed [23:0] y_max,
	input  logic signed [23:0] z_max,
	output logic out_valid,
	input  logic out_ready,
	output logic inside_res
);
	vfc_pkg::item_t in_item, q_item;
	vfc_pkg::coef_t coef [vfc_pkg::NumPlanes][4];
	logic q_valid, q_ready;
	logic coef_busy;

	assign pready = 1'b1;
	assign in_item = '{cmd: command, x_min: x_min, y_min: y_min, z_min: z_min,
		x_max: x_max, y_max: y_max, z_max: z_max};

	vfc_planes u_planes (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .coef,
		.coef_busy
	);

	vfc_front #(.Depth(QueueDepth)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_item,
		.q_valid, .q_ready, .q_item
	);

	vfc_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item, .coef, .coef_busy,
		.out_valid, .out_ready, .inside_res
	);

	// A stalled result holds until taken.
	`VFC_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(inside_res))
	// The queue hands items to the back end only when the back end advances.
	`VFC_ASSERT(a_q_ready, clk, arst_n, !out_ready && out_valid |-> !q_ready)
	// Nothing is output straight out of reset.
	`VFC_ASSERT_NORST(a_reset, clk, !arst_n |=> !out_valid)
endmodule
